### sv/hbs_pkg.sv
package hbs_pkg;

    localparam int MaxDim      = 256;
    localparam int MaxRadius   = 7;
    localparam int CoordW      = $clog2(MaxDim);
    localparam int AddrW       = 2 * CoordW;
    localparam int DimW        = 9;
    localparam int RadW        = $clog2(MaxRadius + 1);
    localparam int OffW        = RadW + 1;
    localparam int QueueDepth  = 2;
    localparam int QPtrW       = $clog2(QueueDepth);

    localparam logic signed [15:0] VoidHeight = 16'sh8000;
    localparam logic [16:0]        OneQ16     = 17'h10000;
    localparam logic signed [27:0] HalfTurn   = 28'sd11796480;
    localparam logic signed [27:0] FullTurn   = 28'sd23592960;

    localparam logic [1:0] RegDim   = 2'd0;
    localparam logic [1:0] RegSouth = 2'd1;
    localparam logic [1:0] RegWest  = 2'd2;

    localparam logic OpWrite  = 1'b0;
    localparam logic OpSample = 1'b1;

    typedef struct packed {
        logic              is_sample;
        logic [AddrW-1:0]  waddr;
        logic              wvalid;
        logic [15:0]       wdata;
        logic [CoordW-1:0] x0;
        logic [CoordW-1:0] y0;
        logic [16:0]       a;
        logic [16:0]       b;
    } hbs_cmd_t;

endpackage

### sv/hbs_front.sv
module hbs_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [15:0]            write_index,
    input  logic signed [15:0]     write_height,
    input  logic signed [23:0]     query_lat,
    input  logic signed [24:0]     query_lon,
    input  logic [8:0]             dim,
    input  logic signed [7:0]      south,
    input  logic signed [8:0]      west,
    output logic                   cmd_valid,
    output hbs_pkg::hbs_cmd_t      cmd,
    input  logic                   cmd_stall
);
    import hbs_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_MUL  = 2'b10
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic              op_reg;
    logic [15:0]       widx_reg;
    logic [15:0]       wh_reg;
    logic [16:0]       u_reg, v_reg;
    logic [8:0]        dim_reg;
    logic              out_valid_reg, out_valid_next;
    hbs_cmd_t          cmd_reg, cmd_next;

    logic signed [27:0] t0, t1, t2;
    logic signed [27:0] ucl;
    logic signed [27:0] vcl;
    logic [8:0]         dimc;
    logic [8:0]         dm1;
    logic [25:0]        xp, yp;
    logic [16:0]        wrow, wcol;
    logic [31:0]        wprod;

    always_comb
    begin
        if (dim < 9'd2)
            dimc = 9'd2;
        else if (dim > 9'(MaxDim))
            dimc = 9'(MaxDim);
        else
            dimc = dim;
        t0 = 28'(query_lon) - (28'(west) <<< 16) + HalfTurn;
        t1 = t0;
        if (t1 >= FullTurn)
            t1 = t1 - FullTurn;
        else if (t1 < 0)
            t1 = t1 + FullTurn;
        if (t1 < 0)
            t1 = t1 + FullTurn;
        t2 = t1 - HalfTurn;
        ucl = (t2 < 0) ? 28'sd0 : ((t2 > 28'sd65536) ? 28'sd65536 : t2);
        vcl = ((28'(south) + 28'sd1) <<< 16) - 28'(query_lat);
        vcl = (vcl < 0) ? 28'sd0 : ((vcl > 28'sd65536) ? 28'sd65536 : vcl);
    end

    assign dm1  = dim_reg - 9'd1;
    assign xp   = 26'(u_reg) * 26'(dm1);
    assign yp   = 26'(v_reg) * 26'(dm1);
    assign wrow = 17'(write_index) / 17'(1);
    assign wcol = 17'(dimc);
    assign wprod = 32'(wrow);

    assign in_stall = (state_reg != F_IDLE) || (out_valid_reg && cmd_stall);
    assign cmd_valid = out_valid_reg;
    assign cmd = cmd_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        if (out_valid_reg && !cmd_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (opcode == OpWrite)
                    begin
                        cmd_next = '0;
                        cmd_next.is_sample = 1'b0;
                        cmd_next.waddr  = AddrW'(wprod);
                        cmd_next.wvalid = (wprod < 32'(MaxDim * MaxDim)) && (wcol != 17'd0);
                        cmd_next.wdata  = write_height;
                        out_valid_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                if (!out_valid_reg || !cmd_stall)
                begin
                    cmd_next = '0;
                    cmd_next.is_sample = 1'b1;
                    cmd_next.x0 = CoordW'(xp[25:16]);
                    cmd_next.y0 = CoordW'(yp[25:16]);
                    cmd_next.a  = {1'b0, xp[15:0]};
                    cmd_next.b  = {1'b0, yp[15:0]};
                    out_valid_next = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (state_reg == F_IDLE && in_valid && !in_stall)
        begin
            op_reg   <= opcode;
            widx_reg <= write_index;
            wh_reg   <= write_height;
            u_reg    <= 17'(ucl);
            v_reg    <= 17'(vcl);
            dim_reg  <= dimc;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_MUL) |-> $past(state_reg) == F_IDLE || $past(state_reg) == F_MUL)
        else $error("mul state entered wrongly");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.is_sample) |-> cmd.a <= 17'h0FFFF)
        else $error("weight out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_stall) |=> cmd_valid)
        else $error("command dropped");

endmodule

### sv/hbs_queue.sv
module hbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  hbs_pkg::hbs_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output hbs_pkg::hbs_cmd_t out_cmd
);
    import hbs_pkg::*;

    hbs_cmd_t         mem_reg [QueueDepth];
    logic [QPtrW-1:0] wp_reg, rp_reg;
    logic [QPtrW:0]   cnt_reg;
    logic             push, pop;

    assign in_stall  = (cnt_reg == (QPtrW+1)'(QueueDepth));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push = in_valid && !in_stall;
    assign pop  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPtrW+1)'(QueueDepth))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("count slip");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> wp_reg == rp_reg)
        else $error("pointer slip");

endmodule

### sv/hbs_back.sv
module hbs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  hbs_pkg::hbs_cmd_t   cmd,
    input  logic [8:0]          dim,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  height_q16
);
    import hbs_pkg::*;

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_ISSUE = 7'b0000010,
        B_WAIT  = 7'b0000100,
        B_CHECK = 7'b0001000,
        B_MIXR  = 7'b0010000,
        B_MIXC  = 7'b0100000,
        B_OUT   = 7'b1000000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [15:0] store [MaxDim*MaxDim];
    logic [15:0] rdata_reg;
    logic [AddrW-1:0] raddr;

    hbs_cmd_t          c_reg;
    logic [8:0]        dim_reg;
    logic [1:0]        corner_reg, corner_next;
    logic              search_reg, search_next;
    logic [RadW-1:0]   r_reg, r_next;
    logic signed [OffW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [15:0] h_reg [4];
    logic signed [15:0] h_next;
    logic              h_we;
    logic signed [49:0] top_reg, bot_reg;
    logic signed [33:0] p0_reg, p1_reg;
    logic signed [49:0] sum_reg;
    logic signed [31:0] res_reg;
    logic              ov_reg, ov_next;
    logic              mix_half_reg;

    logic signed [11:0] bx, by, px, py, mx;
    logic [CoordW-1:0]  cx, cy;
    logic [8:0]         dimc;

    always_comb
    begin
        if (dim < 9'd2)
            dimc = 9'd2;
        else if (dim > 9'(MaxDim))
            dimc = 9'(MaxDim);
        else
            dimc = dim;
    end

    always_comb
    begin
        bx = 12'(c_reg.x0) + 12'(corner_reg[0]);
        by = 12'(c_reg.y0) + 12'(corner_reg[1]);
        if (search_reg)
        begin
            px = bx + 12'(dx_reg);
            py = by + 12'(dy_reg);
        end
        else
        begin
            px = bx;
            py = by;
        end
        mx = 12'(dim_reg) - 12'sd1;
        px = (px < 0) ? 12'sd0 : ((px > mx) ? mx : px);
        py = (py < 0) ? 12'sd0 : ((py > mx) ? mx : py);
        cx = CoordW'(px);
        cy = CoordW'(py);
    end

    assign raddr = AddrW'(cy * 16'(dim_reg) + 16'(cx));

    assign cmd_stall = (state_reg != B_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign height_q16 = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        search_next = search_reg;
        r_next      = r_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        ov_next     = ov_reg;
        h_we        = 1'b0;
        h_next      = $signed(rdata_reg);
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && !ov_reg && cmd.is_sample)
                begin
                    state_next  = B_ISSUE;
                    corner_next = 2'd0;
                    search_next = 1'b0;
                end
            end
            B_ISSUE:
            begin
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if ($signed(rdata_reg) != VoidHeight
                    || (search_reg && r_reg == RadW'(MaxRadius)
                        && dx_reg == OffW'(MaxRadius) && dy_reg == OffW'(MaxRadius)))
                begin
                    h_we = 1'b1;
                    if ($signed(rdata_reg) == VoidHeight)
                        h_next = 16'sd0;
                    search_next = 1'b0;
                    if (corner_reg == 2'd3)
                        state_next = B_MIXR;
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        state_next  = B_ISSUE;
                    end
                end
                else
                begin
                    state_next = B_ISSUE;
                    if (!search_reg)
                    begin
                        search_next = 1'b1;
                        r_next  = RadW'(1);
                        dx_next = -OffW'(1);
                        dy_next = -OffW'(1);
                    end
                    else if (dx_reg != OffW'(r_reg))
                        dx_next = dx_reg + OffW'(1);
                    else if (dy_reg != OffW'(r_reg))
                    begin
                        dx_next = -OffW'(r_reg);
                        dy_next = dy_reg + OffW'(1);
                    end
                    else
                    begin
                        r_next  = r_reg + RadW'(1);
                        dx_next = -OffW'(r_reg + RadW'(1));
                        dy_next = -OffW'(r_reg + RadW'(1));
                    end
                end
            end
            B_MIXR:
            begin
                if (mix_half_reg)
                    state_next = B_MIXC;
            end
            B_MIXC:
            begin
                if (mix_half_reg)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            ov_reg       <= 1'b0;
            corner_reg   <= '0;
            search_reg   <= 1'b0;
            mix_half_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            corner_reg <= corner_next;
            search_reg <= search_next;
            if (state_reg == B_MIXR || state_reg == B_MIXC)
                mix_half_reg <= !mix_half_reg;
            else
                mix_half_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        if (state_reg == B_IDLE && cmd_valid && !ov_reg)
        begin
            c_reg   <= cmd;
            dim_reg <= dimc;
        end
        if (state_reg == B_IDLE && cmd_valid && !ov_reg && !cmd.is_sample && cmd.wvalid)
            store[cmd.waddr] <= cmd.wdata;
        if (state_reg == B_ISSUE)
            rdata_reg <= store[raddr];
        if (h_we)
            h_reg[corner_reg] <= h_next;
        if (state_reg == B_MIXR)
        begin
            if (!mix_half_reg)
            begin
                p0_reg <= $signed({1'b0, OneQ16 - c_reg.a}) * h_reg[0];
                p1_reg <= $signed({1'b0, c_reg.a}) * h_reg[1];
                top_reg <= 50'(p0_reg) + 50'(p1_reg);
            end
            else
            begin
                top_reg <= 50'($signed({1'b0, OneQ16 - c_reg.a}) * h_reg[0])
                         + 50'($signed({1'b0, c_reg.a}) * h_reg[1]);
                bot_reg <= 50'($signed({1'b0, OneQ16 - c_reg.a}) * h_reg[2])
                         + 50'($signed({1'b0, c_reg.a}) * h_reg[3]);
            end
        end
        if (state_reg == B_MIXC)
        begin
            if (!mix_half_reg)
                sum_reg <= 50'($signed({1'b0, OneQ16 - c_reg.b}) * top_reg);
            else
                sum_reg <= sum_reg + 50'($signed({1'b0, c_reg.b}) * bot_reg);
        end
        if (state_reg == B_OUT)
            res_reg <= 32'(sum_reg >>> 16);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && !ov_reg) |=> ov_reg)
        else $error("result not raised");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg && $stable(res_reg))
        else $error("result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        search_reg |-> (state_reg != B_IDLE))
        else $error("search left active");

endmodule

### sv/heightmap_bilinear_sampler_core.sv
// channel  | handshake              | payload
// in       | in_valid / in_stall    | opcode, write_index, write_height, query_lat, query_lon
// out      | out_valid / out_stall  | height_q16
// cfg      | apb psel/penable/...   | tile_dimension, tile_south, tile_west
// a sample takes 4 corner reads and two mix stages; each void search step adds one store read.
// the single-port height memory bounds the rate.
// reset clears control and config; the height store is undefined until written.
// a 2-entry queue parts front and back so each stalls on its own.
module heightmap_bilinear_sampler_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [15:0]        write_index,
    input  logic signed [15:0] write_height,
    input  logic signed [23:0] query_lat,
    input  logic signed [24:0] query_lon,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] height_q16
);
    import hbs_pkg::*;

    logic [8:0]        dim_reg;
    logic signed [7:0] south_reg;
    logic signed [8:0] west_reg;
    logic [1:0]        ridx;

    logic     f_valid, f_stall, q_valid, q_stall;
    hbs_cmd_t f_cmd, q_cmd;

    assign pready = 1'b1;
    assign ridx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= 9'd256;
            south_reg <= '0;
            west_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                RegDim:   dim_reg   <= pwdata[8:0];
                RegSouth: south_reg <= pwdata[7:0];
                RegWest:  west_reg  <= pwdata[8:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            RegDim:   prdata = 32'(dim_reg);
            RegSouth: prdata = 32'(signed'(south_reg));
            RegWest:  prdata = 32'(signed'(west_reg));
            default:  prdata = '0;
        endcase
    end

    hbs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .write_index(write_index), .write_height(write_height),
        .query_lat(query_lat), .query_lon(query_lon),
        .dim(dim_reg), .south(south_reg), .west(west_reg),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_stall(f_stall)
    );

    hbs_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_stall(f_stall), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_stall(q_stall), .out_cmd(q_cmd)
    );

    hbs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd(q_cmd),
        .dim(dim_reg),
        .out_valid(out_valid), .out_stall(out_stall), .height_q16(height_q16)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hbs_pkg::*;

    class height_scoreboard;
        logic [15:0] heights [0:65535];
        longint      dim_reg;
        longint      south_deg;
        longint      west_deg;
        int          wanted_q [$];
        int          errors;
        int          samples_checked;

        function new();
            dim_reg = 256;
            south_deg = 0;
            west_deg = 0;
            errors = 0;
            samples_checked = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint corner_raw(longint d, longint x, longint y);
            longint cx;
            longint cy;
            cx = clip(x, 0, d - 1);
            cy = clip(y, 0, d - 1);
            return longint'($signed(heights[cy * d + cx]));
        endfunction

        // nearest non-void height in growing squares, else zero
        function longint corner_filled(longint d, longint x, longint y);
            longint h;
            h = corner_raw(d, x, y);
            if (h != -32768)
                return h;
            for (int r = 1; r <= MaxRadius; r++)
                for (int dy = -r; dy <= r; dy++)
                    for (int dx = -r; dx <= r; dx++)
                    begin
                        h = corner_raw(d, x + dx, y + dy);
                        if (h != -32768)
                            return h;
                    end
            return 0;
        endfunction

        function int interpolate(logic [23:0] lat_bits, logic [24:0] lon_bits);
            longint d, lat, lon, t, u, v, x, y, x0, y0, a, b;
            longint top, bot, sum;
            d = clip(dim_reg, 2, MaxDim);
            lat = longint'($signed(lat_bits));
            lon = longint'($signed(lon_bits));
            t = lon - west_deg * 65536 + 64'sd11796480;
            t = t % 64'sd23592960;
            if (t < 0)
                t += 64'sd23592960;
            u = clip(t - 64'sd11796480, 0, 65536);
            v = clip((south_deg + 1) * 65536 - lat, 0, 65536);
            x = u * (d - 1);
            y = v * (d - 1);
            x0 = x / 65536;
            y0 = y / 65536;
            a = x - x0 * 65536;
            b = y - y0 * 65536;
            top = (65536 - a) * corner_filled(d, x0, y0) + a * corner_filled(d, x0 + 1, y0);
            bot = (65536 - a) * corner_filled(d, x0, y0 + 1)
                + a * corner_filled(d, x0 + 1, y0 + 1);
            sum = (65536 - b) * top + b * bot;
            return int'(sum >>> 16);
        endfunction

        function void note_item(logic op, logic [15:0] idx, logic [15:0] h,
                                logic [23:0] lat, logic [24:0] lon);
            if (op == OpWrite)
                heights[idx] = h;
            else
                wanted_q.push_back(interpolate(lat, lon));
        endfunction

        function void report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endfunction

        function void check_height(logic signed [31:0] got);
            int want;
            if (wanted_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected height %0d", got));
                return;
            end
            want = wanted_q.pop_front();
            samples_checked++;
            if (got !== want)
                report_mismatch($sformatf("height_q16 got %0d want %0d", got, want));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               opcode;
    logic [15:0]        write_index;
    logic signed [15:0] write_height;
    logic signed [23:0] query_lat;
    logic signed [24:0] query_lon;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] height_q16;

    height_scoreboard sb;
    int  hold_cycles;
    int  idle_cycles;
    int  stall_mode;
    int  mode_count;
    bit  no_gaps;
    int  configs_run;

    heightmap_bilinear_sampler_core DUT (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (mode_count == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_count <= $urandom_range(20, 120);
        end
        else
            mode_count <= mode_count - 1;
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 2) == 0);
        else
            out_stall <= (mode_count % 5 < 3);
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_height(height_q16);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000)
        begin
            $display("watchdog expired at %0t", $time);
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [15:0] idx, logic [15:0] h,
                             logic [23:0] lat, logic [24:0] lon);
        opcode <= op;
        write_index <= idx;
        write_height <= h;
        query_lat <= lat;
        query_lon <= lon;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(op, idx, h, lat, lon);
    endtask

    task automatic maybe_gap();
        int g;
        g = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.wanted_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] reg_id, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_id, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (reg_id)
            RegDim:   sb.dim_reg = value[8:0];
            RegSouth: sb.south_deg = longint'($signed(value[7:0]));
            RegWest:  sb.west_deg = longint'($signed(value[8:0]));
            default:  ;
        endcase
    endtask

    task automatic set_tile(int d, int s, int w);
        drain();
        write_reg(RegDim, d);
        write_reg(RegSouth, s);
        write_reg(RegWest, w);
        configs_run++;
    endtask

    function automatic logic [15:0] random_height();
        return ($urandom_range(0, 5) == 0) ? 16'h8000 : 16'($urandom);
    endfunction

    task automatic send_sample_in_tile();
        longint lat;
        longint lon;
        lat = (sb.south_deg + 1) * 65536 - $urandom_range(0, 65536);
        lon = sb.west_deg * 65536 + $urandom_range(0, 65536);
        case ($urandom_range(0, 9))
            0: lat += $urandom_range(0, 131072) - 65536;
            1: lon += (longint'($urandom_range(0, 2)) - 1) * 23592960;
            2: lon += $urandom_range(0, 131072) - 65536;
            3: lat = longint'($signed(24'($urandom)));
            4: lon = longint'($signed(25'($urandom)));
            default: ;
        endcase
        send_item(OpSample, 16'($urandom), 16'($urandom), 24'(lat), 25'(lon));
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                send_item(OpWrite, 16'($urandom), random_height(),
                          24'($urandom), 25'($urandom));
            else
                send_sample_in_tile();
            maybe_gap();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        opcode = 1'b0;
        write_index = '0;
        write_height = '0;
        query_lat = '0;
        query_lon = '0;
        out_stall = 1'b0;
        hold_cycles = 0;
        idle_cycles = 0;
        stall_mode = 0;
        mode_count = 0;
        no_gaps = 1'b1;
        configs_run = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the whole store so that no read touches an unwritten height
        for (int i = 0; i < 65536; i++)
            send_item(OpWrite, 16'(i), random_height(), 24'($urandom), 25'($urandom));
        no_gaps = 1'b0;

        // directed corners, extremes and wrap
        send_item(OpWrite, 16'd0, 16'h7fff, '0, '0);
        send_item(OpWrite, 16'd65535, 16'h8000, '0, '0);
        send_item(OpWrite, 16'd257, 16'h8000, '0, '0);
        send_item(OpSample, '0, '0, 24'sd65536, 25'sd0);
        send_item(OpSample, '0, '0, 24'sd0, 25'sd65536);
        send_item(OpSample, '0, '0, 24'sd32768, 25'sd32768);
        send_item(OpSample, '0, '0, 24'sh7fffff, 25'sh0ffffff);
        send_item(OpSample, '0, '0, 24'sh800000, 25'sh1000000);
        send_item(OpSample, '0, '0, 24'sd5898240, -25'sd11796480);
        send_item(OpSample, '0, '0, -24'sd5898240, 25'sd11796480);
        send_item(OpSample, '0, '0, 24'sd40000, 25'sd23592960 + 25'sd1000);
        send_item(OpSample, '0, '0, 24'sd40000, 25'sd1000 - 25'sd23592960);
        set_tile(2, 0, 0);
        for (int i = 0; i < 4; i++)
            send_item(OpWrite, 16'(i), 16'h8000, '0, '0);
        send_item(OpSample, '0, '0, 24'sd30000, 25'sd30000);
        send_item(OpWrite, 16'd3, 16'h7fff, '0, '0);
        send_item(OpSample, '0, '0, 24'sd30000, 25'sd30000);
        send_item(OpWrite, 16'd0, 16'h8001, '0, '0);
        send_item(OpSample, '0, '0, 24'sd65536, 25'sd0);
        send_item(OpSample, '0, '0, 24'sd0, 25'sd65536);
        send_item(OpWrite, 16'd1, 16'h0000, '0, '0);
        send_item(OpSample, '0, '0, 24'sd12345, 25'sd54321);

        set_tile(256, 0, 0);
        hold_cycles = 400;
        run_random(150);
        set_tile(2, -90, -180);
        run_random(120);
        set_tile(255, 89, 179);
        run_random(150);
        set_tile(0, -128, -256);
        run_random(100);
        set_tile(511, 127, 255);
        hold_cycles = 300;
        run_random(120);
        set_tile(1, 45, -100);
        run_random(100);
        for (int k = 0; k < 5; k++)
        begin
            set_tile($urandom_range(2, 256), $urandom_range(0, 179) - 90,
                     $urandom_range(0, 359) - 180);
            run_random(110);
        end
        drain();

        $display("covered %0d tile settings and %0d checked samples over a full store load",
                 configs_run, sb.samples_checked);
        $display("void fill, edge clamping, longitude wrap and stall pressure exercised");
        if (sb.errors == 0 && sb.wanted_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
